// ===== sv/pmtg_pkg.sv =====
`default_nettype none

package pmtg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 32;
  localparam int DEV_BITS       = 24;
  localparam int AMP_BITS       = 15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CARRIER_STEP   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOD_STEP       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_DEVIATION = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE      = 2'd3;

  localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET = 15'd32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DEV,
    ST_TOT,
    ST_COS,
    ST_SIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_mod;
    logic calc_dev;
    logic calc_tot;
    logic rd_cos;
    logic rd_sin;
    logic scale_i;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // quarter-wave sine entry, Q2.30 Taylor series, evaluated at elaboration
  function automatic logic [63:0] sine_entry(input int k, input int tab_bits,
                                             input int sample_bits);
    logic [63:0] n_tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] full;
    logic [63:0] v;
    n_tab = 64'd1 << tab_bits;
    x = (HALF_PI_Q30 * 64'(2 * k + 1) + n_tab) >> (tab_bits + 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      unique case (n)
        1: begin
          term = term / 64'd6;
        end
        2: begin
          term = term / 64'd20;
        end
        3: begin
          term = term / 64'd42;
        end
        4: begin
          term = term / 64'd72;
        end
        5: begin
          term = term / 64'd110;
        end
        6: begin
          term = term / 64'd156;
        end
        default: begin
          term = term / 64'd210;
        end
      endcase
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    full = (64'd1 << (sample_bits - 1)) - 64'd1;
    v = (sum * full + (64'd1 << 29)) >> 30;
    if (v > full) begin
      v = full;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pmtg_sine_rom.sv =====
`default_nettype none

module pmtg_sine_rom #(
  parameter int TABLE_ADDR_BITS = pmtg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = pmtg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [TABLE_ADDR_BITS-1:0] rd_addr,
  input  wire logic                       rd_neg,
  output logic      [SAMPLE_BITS-2:0]     mag,
  output logic                            neg
);

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;

  logic [SAMPLE_BITS-2:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic [63:0] V = pmtg_pkg::sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS);
    assign rom[k] = V[SAMPLE_BITS-2:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mag <= rom[rd_addr];
      neg <= rd_neg;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pmtg_ctrl.sv =====
`default_nettype none

module pmtg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire pmtg_pkg::status_t status,
  output pmtg_pkg::cmd_t         cmd
);

  pmtg_pkg::state_t state;
  pmtg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmtg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmtg_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = pmtg_pkg::ST_MOD;
        end
      end
      pmtg_pkg::ST_MOD: begin
        state_next = pmtg_pkg::ST_DEV;
      end
      pmtg_pkg::ST_DEV: begin
        state_next = pmtg_pkg::ST_TOT;
      end
      pmtg_pkg::ST_TOT: begin
        state_next = pmtg_pkg::ST_COS;
      end
      pmtg_pkg::ST_COS: begin
        state_next = pmtg_pkg::ST_SIN;
      end
      pmtg_pkg::ST_SIN: begin
        state_next = pmtg_pkg::ST_EMIT;
      end
      pmtg_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = pmtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pmtg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      pmtg_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      pmtg_pkg::ST_MOD: begin
        cmd.rd_mod = 1'b1;
      end
      pmtg_pkg::ST_DEV: begin
        cmd.calc_dev = 1'b1;
      end
      pmtg_pkg::ST_TOT: begin
        cmd.calc_tot = 1'b1;
      end
      pmtg_pkg::ST_COS: begin
        cmd.rd_cos = 1'b1;
      end
      pmtg_pkg::ST_SIN: begin
        cmd.scale_i = 1'b1;
        cmd.rd_sin  = 1'b1;
      end
      pmtg_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pmtg_datapath.sv =====
`default_nettype none

module pmtg_datapath #(
  parameter int PHASE_BITS      = pmtg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = pmtg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = pmtg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire pmtg_pkg::cmd_t                         cmd,
  output pmtg_pkg::status_t                           status,
  input  wire logic                                   restart,
  input  wire logic                                   block_end,
  input  wire logic                                   cfg_valid,
  input  wire logic [pmtg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [pmtg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic                                        sample_valid,
  input  wire logic                                   sample_ready,
  output logic signed [SAMPLE_BITS-1:0]               i_sample,
  output logic signed [SAMPLE_BITS-1:0]               q_sample,
  output logic                                        last
);

  localparam int E  = PHASE_BITS - 15 - SAMPLE_BITS;
  localparam int PW = SAMPLE_BITS + pmtg_pkg::DEV_BITS + 1;
  localparam int DW = PW + PHASE_BITS;
  localparam int SW = SAMPLE_BITS + 15;

  logic [pmtg_pkg::STEP_BITS-1:0] carrier_step;
  logic [pmtg_pkg::STEP_BITS-1:0] mod_step;
  logic [pmtg_pkg::DEV_BITS-1:0]  peak_deviation;
  logic [pmtg_pkg::AMP_BITS-1:0]  amplitude;

  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] mod_phase;
  logic [PHASE_BITS-1:0] total;
  logic signed [PW-1:0]  prod;
  logic signed [SAMPLE_BITS-1:0] i_hold;
  logic                  last_hold;

  logic [PHASE_BITS-1:0]      phase_src;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] addr_raw;
  logic [TABLE_ADDR_BITS-1:0] rd_addr;
  logic                       rd_en;
  logic [SAMPLE_BITS-2:0]     rom_mag;
  logic                       rom_neg;

  logic signed [SAMPLE_BITS-1:0] mag_s;
  logic signed [SAMPLE_BITS-1:0] cm;
  logic signed [DW-1:0]          prod_ext;
  logic signed [DW-1:0]          dev_shift;
  logic [PHASE_BITS-1:0]         dphase;
  logic [SW-1:0]                 scale_sum;
  logic [SAMPLE_BITS-1:0]        scale_mag;
  logic signed [SAMPLE_BITS-1:0] scaled;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step   <= '0;
      mod_step       <= '0;
      peak_deviation <= '0;
      amplitude      <= pmtg_pkg::AMPLITUDE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmtg_pkg::REG_CARRIER_STEP: begin
          carrier_step <= cfg_data;
        end
        pmtg_pkg::REG_MOD_STEP: begin
          mod_step <= cfg_data;
        end
        pmtg_pkg::REG_PEAK_DEVIATION: begin
          peak_deviation <= cfg_data[pmtg_pkg::DEV_BITS-1:0];
        end
        pmtg_pkg::REG_AMPLITUDE: begin
          amplitude <= cfg_data[pmtg_pkg::AMP_BITS-1:0];
        end
        default: begin
          amplitude <= amplitude;
        end
      endcase
    end
  end

  // table lookup: quadrant folding, cosine is sine a quarter turn on
  assign phase_src = cmd.rd_mod ? mod_phase : total;
  assign quad      = phase_src[PHASE_BITS-1 -: 2] + {1'b0, cmd.rd_mod | cmd.rd_cos};
  assign addr_raw  = phase_src[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rd_addr   = quad[0] ? ~addr_raw : addr_raw;
  assign rd_en     = cmd.rd_mod | cmd.rd_cos | cmd.rd_sin;

  pmtg_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_neg  (quad[1]),
    .mag     (rom_mag),
    .neg     (rom_neg)
  );

  // deviation
  assign mag_s    = $signed({1'b0, rom_mag});
  assign cm       = rom_neg ? -mag_s : mag_s;
  assign prod_ext = DW'(prod);

  if (E >= 0) begin : g_dev_left
    assign dev_shift = prod_ext <<< E;
  end else begin : g_dev_right
    localparam int S = -E;
    localparam logic signed [DW-1:0] HALF = DW'(1) <<< (S - 1);
    assign dev_shift = (prod_ext + HALF) >>> S;
  end

  assign dphase = dev_shift[PHASE_BITS-1:0];

  // output scaling, round half away from zero
  assign scale_sum = SW'(amplitude) * SW'(rom_mag) + SW'(1 << 14);
  assign scale_mag = scale_sum[SW-1:15];
  assign scaled    = rom_neg ? -$signed(scale_mag) : $signed(scale_mag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_hold <= block_end;
    end
    if (cmd.calc_dev) begin
      prod <= $signed({1'b0, peak_deviation}) * cm;
    end
    if (cmd.calc_tot) begin
      total <= carrier_phase + dphase;
    end
    if (cmd.scale_i) begin
      i_hold <= scaled;
    end
    if (cmd.emit) begin
      i_sample <= i_hold;
      q_sample <= scaled;
      last     <= last_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
      mod_phase     <= '0;
    end else if (cmd.load && restart) begin
      carrier_phase <= '0;
      mod_phase     <= '0;
    end else if (cmd.emit) begin
      carrier_phase <= carrier_phase + (PHASE_BITS)'(carrier_step);
      mod_phase     <= mod_phase + (PHASE_BITS)'(mod_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (cmd.emit) begin
      sample_valid <= 1'b1;
    end else if (sample_ready) begin
      sample_valid <= 1'b0;
    end
  end

  assign status.out_free = !sample_valid || sample_ready;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!sample_valid || sample_ready))
    else $error("word overwritten in output register");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && restart) |=> (carrier_phase == '0 && mod_phase == '0))
    else $error("restart did not clear phases");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (!cmd.emit && !cmd.load) |=> ($stable(carrier_phase) && $stable(mod_phase)))
    else $error("phase moved outside emit");

endmodule

`default_nettype wire

// ===== sv/phase_modulated_tone_generator.sv =====
`default_nettype none

// Phase-modulated tone generator: each accepted input word yields one complex
// sample, amplitude times cos/sin of the carrier phase plus peak_deviation
// times the cosine of the modulation phase; restart zeroes both phases before
// the sample is formed, block_end comes back as last. The sequencer walks
// three lookups of the single-port quarter-wave ROM (registered read) and
// the deviation multiply one step a cycle. An output register holds a
// finished sample, so the next word is accepted and worked on while it
// waits; a stalled output holds the block in its final step. The sine
// table is constant, no clearing pass after reset. Configuration must be
// written only while idle, unenforced by the block; cfg_ready is always high.

module phase_modulated_tone_generator #(
  parameter int PHASE_BITS      = pmtg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = pmtg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = pmtg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic                                restart,
  input  wire logic                                block_end,
  output logic                                     sample_valid,
  input  wire logic                                sample_ready,
  output logic signed [SAMPLE_BITS-1:0]            i_sample,
  output logic signed [SAMPLE_BITS-1:0]            q_sample,
  output logic                                     last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pmtg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pmtg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  pmtg_pkg::cmd_t    cmd;
  pmtg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pmtg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pmtg_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .restart      (restart),
    .block_end    (block_end),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .last         (last)
  );

endmodule

`default_nettype wire
